### design/selective_repeat_receive_window_assert.svh
// Assertion macros for the selective-repeat receive window.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH

// Implication checked at each clock edge while out of reset.
`define SRRW_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define SRRW_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### design/srrw_pkg.sv
// Shared constants and types for the selective-repeat receive window.
// No dependencies.
package srrw_pkg;

    localparam int WINDOW       = 8;
    localparam int SEQ_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int SEQ_W  = 16;
    localparam int PAY_W  = 32;
    localparam int IDX_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [63:0] SEQ_MASK64 = (64'd1 << SEQ_BITS) - 64'd1;
    localparam logic [63:0] PAY_MASK64 = (64'd1 << PAYLOAD_BITS) - 64'd1;
    localparam logic [SEQ_W-1:0] SEQ_MASK = SEQ_MASK64[SEQ_W-1:0];
    localparam logic [PAY_W-1:0] PAY_MASK = PAY_MASK64[PAY_W-1:0];

    localparam int SLOT_W = PAY_W + 1;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_START_SEQUENCE = 1'b0,
        REG_ADAPTIVE_MODE  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_ACK      = 1'b0,
        KIND_DELIVERY = 1'b1
    } result_kind_t;

endpackage

### design/srrw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/selective_repeat_receive_window.sv
// Selective-repeat receive window: a packet 1..WINDOW ahead of the base is stored in a slot
// RAM (payload and final flag) and acked; when it is the next expected one, consecutive
// received slots are released in order, one per cycle unless the output stalls, from the
// registered RAM read. A packet 0..WINDOW behind the base is acked again, anything else
// dropped, and the release of a final packet ends the transfer until start_sequence is
// rewritten. A packet that releases slots holds the input off after its accept while the
// head slot is read from RAM in ST_READ, then while slots go out one per cycle through the
// single output register unless it stalls. Output stalls hold the input off.
// Depends on srrw_pkg, srrw_ram and selective_repeat_receive_window_assert.svh.
`include "selective_repeat_receive_window_assert.svh"

module selective_repeat_receive_window (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [47:0]                             s_tdata,  // seq_number, payload_word
    input  logic                                    s_tlast,  // final_packet
    input  logic                                    s_tuser,  // timing_sample
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [47:0]                             m_tdata,  // result_seq, delivered_payload
    output logic                                    m_tlast,  // run_end
    output logic [2:0]                              m_tuser,  // result_kind, timing_echo,
                                                              // transfer_done
    input  logic                                    cfg_we,
    input  logic [srrw_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [srrw_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DELIVER
    } state_t;

    localparam int IB = srrw_pkg::IDX_BITS;
    localparam int W  = srrw_pkg::WINDOW;
    localparam logic [IB:0] WIN_EXT = (IB+1)'(W);
    localparam logic [IB-1:0] LAST_IDX = IB'(W - 1);

    state_t state_reg, state_next;
    logic [srrw_pkg::SEQ_W-1:0] base_reg, base_next;
    logic [IB-1:0]              head_reg, head_next;
    logic [W-1:0]               recv_reg, recv_next;
    logic                       finished_reg, finished_next;
    logic                       adaptive_reg, adaptive_next;

    logic                       out_valid_reg, out_valid_next;
    srrw_pkg::result_kind_t     out_kind_reg, out_kind_next;
    logic [srrw_pkg::SEQ_W-1:0] out_seq_reg, out_seq_next;
    logic                       out_echo_reg, out_echo_next;
    logic [srrw_pkg::PAY_W-1:0] out_pay_reg, out_pay_next;
    logic                       out_done_reg, out_done_next;
    logic                       out_last_reg, out_last_next;

    logic [srrw_pkg::SEQ_W-1:0] seq_in, ahead, behind, ahead_m1, dlv_seq;
    logic [srrw_pkg::PAY_W-1:0] pay_in;
    logic                       in_window, in_order, behind_ok;
    logic [IB:0]                idx_sum;
    logic [IB-1:0]              wr_idx, head_inc;
    logic                       out_free, accept, load_dlv, dlv_last, echo;
    logic [W-1:0]               cleared;

    logic                       ram_we, ram_re;
    logic [IB-1:0]              ram_raddr;
    logic [srrw_pkg::SLOT_W-1:0] ram_wdata, ram_rdata;
    logic                       rd_final;
    logic [srrw_pkg::PAY_W-1:0] rd_pay;

    assign seq_in   = s_tdata[15:0] & srrw_pkg::SEQ_MASK;
    assign pay_in   = s_tdata[47:16] & srrw_pkg::PAY_MASK;
    assign ahead    = (seq_in - base_reg) & srrw_pkg::SEQ_MASK;
    assign behind   = (base_reg - seq_in) & srrw_pkg::SEQ_MASK;
    assign ahead_m1 = ahead - 16'd1;
    assign in_window = (ahead != '0) && ({16'd0, ahead} <= 32'(W));
    assign in_order  = (ahead == 16'd1);
    assign behind_ok = ({16'd0, behind} <= 32'(W));
    assign echo      = s_tuser & adaptive_reg;

    assign idx_sum = {1'b0, head_reg} + {1'b0, ahead_m1[IB-1:0]};
    assign wr_idx  = (idx_sum >= WIN_EXT) ? IB'(idx_sum - WIN_EXT) : idx_sum[IB-1:0];
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign {rd_final, rd_pay} = ram_rdata;
    assign cleared  = recv_reg & ~(W'(1) << head_reg);
    assign load_dlv = (state_reg == ST_DELIVER) && out_free;
    assign dlv_last = rd_final || !cleared[head_inc];
    assign dlv_seq  = (base_reg + 16'd1) & srrw_pkg::SEQ_MASK;

    assign ram_we    = accept && !finished_reg && in_window;
    assign ram_wdata = {s_tlast, pay_in};
    assign ram_re    = (state_reg == ST_READ) || (load_dlv && !dlv_last);
    assign ram_raddr = (state_reg == ST_READ) ? head_reg : head_inc;

    srrw_ram #(
        .WIDTH(srrw_pkg::SLOT_W),
        .DEPTH(W)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_idx),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        recv_next      = recv_reg;
        finished_next  = finished_reg;
        adaptive_next  = adaptive_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_echo_next  = out_echo_reg;
        out_pay_next   = out_pay_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !finished_reg && (in_window || behind_ok))
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = srrw_pkg::KIND_ACK;
                    out_seq_next   = seq_in;
                    out_echo_next  = echo;
                    out_pay_next   = '0;
                    out_done_next  = 1'b0;
                    out_last_next  = !(in_window && in_order);
                    if (in_window)
                    begin
                        recv_next[wr_idx] = 1'b1;
                        if (in_order)
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (load_dlv)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = srrw_pkg::KIND_DELIVERY;
                    out_seq_next   = dlv_seq;
                    out_echo_next  = 1'b0;
                    out_pay_next   = rd_pay;
                    out_done_next  = rd_final;
                    out_last_next  = dlv_last;
                    recv_next      = cleared;
                    base_next      = dlv_seq;
                    head_next      = head_inc;
                    if (rd_final)
                    begin
                        finished_next = 1'b1;
                    end
                    if (dlv_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                srrw_pkg::REG_START_SEQUENCE:
                begin
                    base_next     = cfg_data & srrw_pkg::SEQ_MASK;
                    head_next     = '0;
                    recv_next     = '0;
                    finished_next = 1'b0;
                end
                srrw_pkg::REG_ADAPTIVE_MODE:
                begin
                    adaptive_next = cfg_data[0];
                end
                default:
                begin
                    adaptive_next = adaptive_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            head_reg      <= '0;
            recv_reg      <= '0;
            finished_reg  <= 1'b0;
            adaptive_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            recv_reg      <= recv_next;
            finished_reg  <= finished_next;
            adaptive_reg  <= adaptive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_echo_reg <= out_echo_next;
        out_pay_reg  <= out_pay_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pay_reg, out_seq_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_done_reg, out_echo_reg, out_kind_reg};

    `SRRW_ASSERT_IMP(a_read_head_valid, state_reg == ST_READ, recv_reg[head_reg],
        "head slot not marked received at read")
    `SRRW_ASSERT_IMP(a_deliver_head_valid, load_dlv, recv_reg[head_reg],
        "delivering a slot that was not received")
    `SRRW_ASSERT_IMP(a_finished_idle, finished_reg, state_reg == ST_IDLE,
        "release continues after transfer end")
    `SRRW_ASSERT_NEXT(a_in_order_reads, accept && !finished_reg && in_window && in_order,
        state_reg == ST_READ, "in-order packet did not start release")

endmodule
